/* sv/lci_pkg.sv */
// ----------------------------------------------------------------------------
// Level curve package
// Shared constants, widths and word types for the tank level curve unit.
// ----------------------------------------------------------------------------
package lci_pkg;

    // Calibration table size and field widths.
    localparam int TABLE_POINTS = 16;
    localparam int ADDR_W       = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS) : 1;
    localparam int RAW_W        = 16;
    localparam int IDX_W        = 4;
    localparam int VAL_W        = 20;

    // Full scale is 100 percent in Q7.8, split as a shift and a small divisor.
    localparam int FULL_SCALE   = 25600;
    localparam int COARSE_SHIFT = 10;
    localparam int FINE_DIV     = FULL_SCALE >> COARSE_SHIFT;
    localparam int GUARD_BITS   = 5;

    // Default entry spacing: five litres in Q11.8.
    localparam int STEP_Q8      = 1280;

    // Segment search: t = reading * (points - 1), then t / FULL_SCALE.
    localparam int REM_W        = $clog2(FULL_SCALE);
    localparam int T_W          = $clog2(FULL_SCALE * (TABLE_POINTS - 1));
    localparam int X_W          = T_W - COARSE_SHIFT;
    localparam int SEG_SHIFT    = X_W + GUARD_BITS;
    localparam int SEG_RECIP_W  = SEG_SHIFT - 4;
    localparam logic [SEG_RECIP_W-1:0] SEG_RECIP =
        SEG_RECIP_W'((64'd1 << SEG_SHIFT) / 64'(FINE_DIV));

    // Blend: floor(rem * diff / FULL_SCALE), biased positive for the divide.
    localparam int DIFF_W        = VAL_W + 1;
    localparam int PROD_W        = REM_W + 1 + DIFF_W;
    localparam int YB_W          = PROD_W - COARSE_SHIFT;
    localparam int BIAS_EXP      = DIFF_W - 1;
    localparam logic [YB_W-1:0] YB_BIAS = YB_W'(64'(FINE_DIV) << BIAS_EXP);
    localparam int Q_W           = YB_W - 4;
    localparam int Q_OFFSET      = 1 << BIAS_EXP;
    localparam int RES_W         = Q_W + 2;
    localparam int BLEND_SHIFT   = YB_W + GUARD_BITS;
    localparam int BLEND_RECIP_W = BLEND_SHIFT - 4;
    localparam logic [BLEND_RECIP_W-1:0] BLEND_RECIP =
        BLEND_RECIP_W'((64'd1 << BLEND_SHIFT) / 64'(FINE_DIV));

    // Pipeline depths of the front and back sections.
    localparam int SEG_STAGES   = 3;
    localparam int BLEND_STAGES = 5;

    // Table write carried alongside a conversion.
    typedef struct packed {
        logic                    is_wr;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
    } lci_wr_t;

    // Request word from the segment finder to the table.
    typedef struct packed {
        lci_wr_t           wr;
        logic [ADDR_W-1:0] lo_addr;
        logic [ADDR_W-1:0] hi_addr;
        logic [REM_W-1:0]  rem;
    } lci_req_t;

    // Neighbouring entries read from the table.
    typedef struct packed {
        logic [REM_W-1:0]        rem;
        logic signed [VAL_W-1:0] lo_data;
        logic signed [VAL_W-1:0] hi_data;
        logic                    lo_vld;
        logic                    hi_vld;
        logic [ADDR_W-1:0]       lo_addr;
        logic [ADDR_W-1:0]       hi_addr;
    } lci_pair_t;

endpackage

/* sv/lci_seg_div.sv */
// ----------------------------------------------------------------------------
// Segment finder
// Three-stage pipeline that clamps the reading, scales it and splits it into
// a table segment and a remainder by reciprocal division.
// ----------------------------------------------------------------------------
module lci_seg_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_action,
    input  logic signed [lci_pkg::RAW_W-1:0] in_raw_level,
    input  logic [lci_pkg::IDX_W-1:0]        in_entry_index,
    input  logic signed [lci_pkg::VAL_W-1:0] in_entry_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output lci_pkg::lci_req_t                out_req
);
    import lci_pkg::*;

    logic [SEG_STAGES-1:0] stg_valid_reg;
    logic [SEG_STAGES-1:0] stg_valid_next;
    logic [SEG_STAGES-1:0] stg_adv;

    // Stage A: clamp flags and scaled reading.
    lci_wr_t          a_wr_reg, a_wr_next;
    logic [T_W-1:0]   a_t_reg, a_t_next;
    logic             a_lo_clamp_reg, a_lo_clamp_next;
    logic             a_hi_clamp_reg, a_hi_clamp_next;

    // Stage B: segment estimate.
    lci_wr_t                      b_wr_reg;
    logic [T_W-1:0]               b_t_reg;
    logic                         b_lo_clamp_reg;
    logic                         b_hi_clamp_reg;
    logic [ADDR_W-1:0]            b_qest_reg, b_qest_next;
    logic [X_W+SEG_RECIP_W-1:0]   b_qprod;

    // Stage C: corrected segment, remainder and read addresses.
    lci_req_t          c_req_reg, c_req_next;
    logic [X_W:0]      c_rest;
    logic [ADDR_W-1:0] c_seg;

    // A stage loads when it is empty or its word moves on.
    always_comb begin
        stg_adv[SEG_STAGES-1] = !stg_valid_reg[SEG_STAGES-1] || out_ready;
        for (int i = SEG_STAGES - 2; i >= 0; i--) begin
            stg_adv[i] = !stg_valid_reg[i] || stg_adv[i+1];
        end
        stg_valid_next[0] = stg_adv[0] ? in_valid : stg_valid_reg[0];
        for (int i = 1; i < SEG_STAGES; i++) begin
            stg_valid_next[i] = stg_adv[i] ? stg_valid_reg[i-1] : stg_valid_reg[i];
        end
    end

    assign in_ready  = stg_adv[0];
    assign out_valid = stg_valid_reg[SEG_STAGES-1];
    assign out_req   = c_req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= '0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // Stage A logic: clamp test and multiply by the number of segments.
    always_comb begin
        a_wr_next.is_wr = in_action;
        a_wr_next.idx   = in_entry_index;
        a_wr_next.val   = in_entry_value;
        a_lo_clamp_next = in_raw_level[RAW_W-1] || (in_raw_level == '0);
        a_hi_clamp_next = !in_raw_level[RAW_W-1] &&
                          (in_raw_level[RAW_W-2:0] >= (RAW_W-1)'(FULL_SCALE));
        if (a_lo_clamp_next || a_hi_clamp_next) begin
            a_t_next = '0;
        end else begin
            a_t_next = T_W'(T_W'(in_raw_level[REM_W-1:0]) * T_W'(TABLE_POINTS - 1));
        end
    end

    // Stage B logic: quotient estimate, at most one below the true value.
    always_comb begin
        b_qprod     = a_t_reg[T_W-1:COARSE_SHIFT] * SEG_RECIP;
        b_qest_next = ADDR_W'(b_qprod >> SEG_SHIFT);
    end

    // Stage C logic: one correction step, remainder and neighbour addresses.
    always_comb begin
        c_rest = (X_W+1)'(b_t_reg[T_W-1:COARSE_SHIFT])
               - (X_W+1)'(b_qest_reg * FINE_DIV);
        c_seg  = b_qest_reg + ADDR_W'(c_rest >= (X_W+1)'(FINE_DIV));
        c_req_next.wr  = b_wr_reg;
        c_req_next.rem = REM_W'(b_t_reg - T_W'(c_seg * FULL_SCALE));
        if (b_hi_clamp_reg) begin
            c_req_next.lo_addr = ADDR_W'(TABLE_POINTS - 1);
        end else begin
            c_req_next.lo_addr = c_seg;
        end
        if (b_lo_clamp_reg || b_hi_clamp_reg) begin
            c_req_next.hi_addr = c_req_next.lo_addr;
        end else begin
            c_req_next.hi_addr = c_seg + ADDR_W'(1);
        end
    end

    // Payload registers follow the stage enables.
    always_ff @(posedge aclk) begin
        if (stg_adv[0]) begin
            a_wr_reg       <= a_wr_next;
            a_t_reg        <= a_t_next;
            a_lo_clamp_reg <= a_lo_clamp_next;
            a_hi_clamp_reg <= a_hi_clamp_next;
        end
        if (stg_adv[1]) begin
            b_wr_reg       <= a_wr_reg;
            b_t_reg        <= a_t_reg;
            b_lo_clamp_reg <= a_lo_clamp_reg;
            b_hi_clamp_reg <= a_hi_clamp_reg;
            b_qest_reg     <= b_qest_next;
        end
        if (stg_adv[2]) begin
            c_req_reg <= c_req_next;
        end
    end

endmodule

/* sv/lci_table.sv */
// ----------------------------------------------------------------------------
// Calibration table
// Two copies of the level table in synchronous memories, one per neighbour
// read port, with per-entry valid bits standing in for the default curve.
// ----------------------------------------------------------------------------
module lci_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  lci_pkg::lci_req_t  in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output lci_pkg::lci_pair_t out_pair
);
    import lci_pkg::*;

    logic signed [VAL_W-1:0] lo_mem [TABLE_POINTS];
    logic signed [VAL_W-1:0] hi_mem [TABLE_POINTS];
    logic [TABLE_POINTS-1:0] vld_reg;

    logic                    out_valid_reg;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] lo_rd_reg, hi_rd_reg;
    logic                    lo_vld_reg, hi_vld_reg;
    logic [ADDR_W-1:0]       lo_addr_reg, hi_addr_reg;
    logic [REM_W-1:0]        rem_reg;

    // A word is taken whenever the read register is free or draining.
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Writes beyond the table are dropped.
    assign wr_en   = in_valid && in_ready && in_req.wr.is_wr &&
                     (32'(in_req.wr.idx) < 32'(TABLE_POINTS));
    assign wr_addr = ADDR_W'(in_req.wr.idx);

    // Only conversions go on to the blend stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid && !in_req.wr.is_wr;
            end
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Both copies take every write.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lo_mem[wr_addr] <= in_req.wr.val;
            hi_mem[wr_addr] <= in_req.wr.val;
        end
    end

    // Registered reads of both neighbours; held while the output stalls.
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            lo_rd_reg   <= lo_mem[in_req.lo_addr];
            hi_rd_reg   <= hi_mem[in_req.hi_addr];
            lo_vld_reg  <= vld_reg[in_req.lo_addr];
            hi_vld_reg  <= vld_reg[in_req.hi_addr];
            lo_addr_reg <= in_req.lo_addr;
            hi_addr_reg <= in_req.hi_addr;
            rem_reg     <= in_req.rem;
        end
    end

    always_comb begin
        out_pair.rem     = rem_reg;
        out_pair.lo_data = lo_rd_reg;
        out_pair.hi_data = hi_rd_reg;
        out_pair.lo_vld  = lo_vld_reg;
        out_pair.hi_vld  = hi_vld_reg;
        out_pair.lo_addr = lo_addr_reg;
        out_pair.hi_addr = hi_addr_reg;
    end

endmodule

/* sv/lci_blend.sv */
// ----------------------------------------------------------------------------
// Interpolation blend
// Five-stage pipeline computing lo + floor(rem * (hi - lo) / full scale).
// ----------------------------------------------------------------------------
module lci_blend (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lci_pkg::lci_pair_t                in_pair,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [lci_pkg::VAL_W-1:0]  out_level
);
    import lci_pkg::*;

    logic [BLEND_STAGES-1:0] stg_valid_reg;
    logic [BLEND_STAGES-1:0] stg_valid_next;
    logic [BLEND_STAGES-1:0] stg_adv;

    // Stage D: resolved neighbours and their difference.
    logic signed [VAL_W-1:0]  d_lo_val, d_hi_val;
    logic signed [VAL_W-1:0]  d_lo_reg;
    logic signed [DIFF_W-1:0] d_diff_reg, d_diff_next;
    logic [REM_W-1:0]         d_rem_reg;

    // Stage E: weighted difference.
    logic signed [PROD_W-1:0] e_prod_reg, e_prod_next;
    logic signed [VAL_W-1:0]  e_lo_reg;

    // Stage F: coarse shift and positive bias.
    logic signed [PROD_W-1:0] f_shift;
    logic [YB_W-1:0]          f_yb_reg, f_yb_next;
    logic signed [VAL_W-1:0]  f_lo_reg;

    // Stage G: quotient estimate by reciprocal.
    logic [YB_W+BLEND_RECIP_W-1:0] g_qprod;
    logic [Q_W-1:0]                g_qest_reg, g_qest_next;
    logic [YB_W-1:0]               g_yb_reg;
    logic signed [VAL_W-1:0]       g_lo_reg;

    // Stage H: correction and final sum.
    logic [YB_W-1:0]         h_rest;
    logic [Q_W-1:0]          h_q;
    logic [RES_W-1:0]        h_sum;
    logic signed [VAL_W-1:0] h_level_reg;

    // Bubble-collapsing stage enables.
    always_comb begin
        stg_adv[BLEND_STAGES-1] = !stg_valid_reg[BLEND_STAGES-1] || out_ready;
        for (int i = BLEND_STAGES - 2; i >= 0; i--) begin
            stg_adv[i] = !stg_valid_reg[i] || stg_adv[i+1];
        end
        stg_valid_next[0] = stg_adv[0] ? in_valid : stg_valid_reg[0];
        for (int i = 1; i < BLEND_STAGES; i++) begin
            stg_valid_next[i] = stg_adv[i] ? stg_valid_reg[i-1] : stg_valid_reg[i];
        end
    end

    assign in_ready  = stg_adv[0];
    assign out_valid = stg_valid_reg[BLEND_STAGES-1];
    assign out_level = h_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= '0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // Stage D: an entry never written reads as its default of five litres a point.
    always_comb begin
        d_lo_val = in_pair.lo_vld ? in_pair.lo_data
                                  : $signed(VAL_W'(32'(in_pair.lo_addr) * STEP_Q8));
        d_hi_val = in_pair.hi_vld ? in_pair.hi_data
                                  : $signed(VAL_W'(32'(in_pair.hi_addr) * STEP_Q8));
        d_diff_next = {d_hi_val[VAL_W-1], d_hi_val} - {d_lo_val[VAL_W-1], d_lo_val};
    end

    // Stage E: signed product of remainder and difference.
    assign e_prod_next = $signed({1'b0, d_rem_reg}) * d_diff_reg;

    // Stage F: floor by the power-of-two part, then bias so the rest is positive.
    always_comb begin
        f_shift   = e_prod_reg >>> COARSE_SHIFT;
        f_yb_next = f_shift[YB_W-1:0] + YB_BIAS;
    end

    // Stage G: estimate of the biased value over the small divisor.
    always_comb begin
        g_qprod     = f_yb_reg * BLEND_RECIP;
        g_qest_next = g_qprod[BLEND_SHIFT +: Q_W];
    end

    // Stage H: one correction step, remove the bias and add the lower entry.
    always_comb begin
        h_rest = g_yb_reg - YB_W'(g_qest_reg * FINE_DIV);
        h_q    = g_qest_reg + Q_W'(h_rest >= YB_W'(FINE_DIV));
        h_sum  = {{(RES_W-VAL_W){g_lo_reg[VAL_W-1]}}, g_lo_reg}
               + RES_W'(h_q) - RES_W'(Q_OFFSET);
    end

    always_ff @(posedge aclk) begin
        if (stg_adv[0]) begin
            d_lo_reg   <= d_lo_val;
            d_diff_reg <= d_diff_next;
            d_rem_reg  <= in_pair.rem;
        end
        if (stg_adv[1]) begin
            e_prod_reg <= e_prod_next;
            e_lo_reg   <= d_lo_reg;
        end
        if (stg_adv[2]) begin
            f_yb_reg <= f_yb_next;
            f_lo_reg <= e_lo_reg;
        end
        if (stg_adv[3]) begin
            g_qest_reg <= g_qest_next;
            g_yb_reg   <= f_yb_reg;
            g_lo_reg   <= f_lo_reg;
        end
        if (stg_adv[4]) begin
            h_level_reg <= $signed(h_sum[VAL_W-1:0]);
        end
    end

endmodule

/* sv/level_curve_interp_unit.sv */
// ----------------------------------------------------------------------------
// Tank level curve unit
// Converts a sender reading in percent to a level in litres by linear
// interpolation over a sixteen-point calibration table.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one word per cycle while s_ready is high. With
//   s_action low it is a conversion of s_raw_level (Q7.8 percent); with
//   s_action high it stores s_entry_value at table point s_entry_index
//   and gives no result. The m_ channel returns one m_level_liters word
//   (Q11.8) per conversion, in the order the conversions were taken.
//   Words pass through the segment division stages, the table read
//   register and the blend stages, in that order.
//   Throughput is one word per cycle while m_ready stays high; the
//   table memories are read and written by the same pipeline stage, so
//   a write is seen by the next word. Reset empties the pipeline and
//   restores the default curve of five litres per point at once, through
//   per-entry valid bits. When the receiver stalls, results stay on m_
//   and words keep entering until every stage is full; then s_ready drops.
// ----------------------------------------------------------------------------
module level_curve_interp_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic signed [lci_pkg::RAW_W-1:0]  s_raw_level,
    input  logic [lci_pkg::IDX_W-1:0]         s_entry_index,
    input  logic signed [lci_pkg::VAL_W-1:0]  s_entry_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [lci_pkg::VAL_W-1:0]  m_level_liters
);
    import lci_pkg::*;

    logic      req_valid, req_ready;
    lci_req_t  req_word;
    logic      pair_valid, pair_ready;
    lci_pair_t pair_word;

    // Segment and remainder.
    lci_seg_div u_seg_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_action      (s_action),
        .in_raw_level   (s_raw_level),
        .in_entry_index (s_entry_index),
        .in_entry_value (s_entry_value),
        .out_valid      (req_valid),
        .out_ready      (req_ready),
        .out_req        (req_word)
    );

    // Table memories: writes land here, conversions read both neighbours.
    lci_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_req    (req_word),
        .out_valid (pair_valid),
        .out_ready (pair_ready),
        .out_pair  (pair_word)
    );

    // Interpolation between the neighbours.
    lci_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pair_valid),
        .in_ready  (pair_ready),
        .in_pair   (pair_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_level (m_level_liters)
    );

endmodule

/* sv/lci_port_checker.sv */
// ----------------------------------------------------------------------------
// Level curve port checker
// Watches the top-level ports for reset, throughput and stall behaviour.
// ----------------------------------------------------------------------------
module lci_port_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [lci_pkg::VAL_W-1:0]  m_level_liters
);
    import lci_pkg::*;

    // Reset leaves the pipeline empty and open for a word.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("pipeline not empty and ready after reset");

    // With the receiver taking every word, the input never stalls.
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is being drained");

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_level_liters)))
        else $error("result word changed or dropped while stalled");

endmodule

bind level_curve_interp_unit lci_port_checker u_port_checker (.*);

/* tb/lci_tb_pkg.sv */
// ----------------------------------------------------------------------------
// Level curve testbench package
// Codes shared by the level curve stimulus and the checker.
// ----------------------------------------------------------------------------
package lci_tb_pkg;

    // Meaning of the s_action bit of an input word.
    typedef enum logic {
        ACT_CONVERT = 1'b0,
        ACT_WRITE   = 1'b1
    } lci_action_e;

endpackage

/* tb/level_curve_interp_checker.sv */
// ----------------------------------------------------------------------------
// Level curve checker
// Watches both channels of the level curve unit. It keeps its own copy of
// the calibration table, predicts the level for every accepted conversion
// word and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module level_curve_interp_checker
    import lci_pkg::*;
    import lci_tb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_action,
    input  logic signed [RAW_W-1:0] s_raw_level,
    input  logic [IDX_W-1:0]        s_entry_index,
    input  logic signed [VAL_W-1:0] s_entry_value,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [VAL_W-1:0] m_level_liters,
    output int                      mismatches,
    output int                      pending
);

    logic signed [VAL_W-1:0] curve_tab [TABLE_POINTS];
    logic signed [VAL_W-1:0] level_due_q [$];
    logic signed [VAL_W-1:0] want;
    int                      fail_total = 0;

    assign mismatches = fail_total;

    // Print one line for a failure and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] level check: %s", $time, what);
        fail_total++;
    endtask

    // Interpolated level for one reading over the current table, floored.
    function automatic logic signed [VAL_W-1:0] interp_level(
        input logic signed [RAW_W-1:0] reading
    );
        longint t;
        longint seg;
        longint rem;
        longint lo;
        longint hi;
        longint num;
        longint q;
        if (reading <= 0) begin
            return curve_tab[0];
        end
        if (longint'(reading) >= FULL_SCALE) begin
            return curve_tab[TABLE_POINTS-1];
        end
        t   = longint'(reading) * (TABLE_POINTS - 1);
        seg = t / FULL_SCALE;
        rem = t % FULL_SCALE;
        if (seg > TABLE_POINTS - 2) begin
            seg = TABLE_POINTS - 2;
        end
        lo  = longint'(curve_tab[seg]);
        hi  = longint'(curve_tab[seg+1]);
        num = rem * (hi - lo);
        q   = num / FULL_SCALE;
        // Division truncates towards zero; a descending segment needs the floor.
        if ((num % FULL_SCALE) != 0 && num < 0) begin
            q = q - 1;
        end
        return VAL_W'(lo + q);
    endfunction

    // Follow the input stream, then the result stream, at every edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_POINTS; i++) begin
                curve_tab[i] = VAL_W'(i * STEP_Q8);
            end
            level_due_q.delete();
            pending <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_action == ACT_WRITE) begin
                    if (s_entry_index < TABLE_POINTS) begin
                        curve_tab[s_entry_index] = s_entry_value;
                    end
                end else begin
                    level_due_q.push_back(interp_level(s_raw_level));
                end
            end
            if (m_valid && m_ready) begin
                if (level_due_q.size() == 0) begin
                    report_mismatch($sformatf("result word %0d with no conversion outstanding",
                                              m_level_liters));
                end else begin
                    want = level_due_q.pop_front();
                    if (m_level_liters !== want) begin
                        report_mismatch($sformatf("level_liters got %0d, want %0d",
                                                  m_level_liters, want));
                    end
                end
            end
            pending <= level_due_q.size();
        end
    end

endmodule

/* tb/level_curve_interp_unit_tb.sv */
// ----------------------------------------------------------------------------
// Level curve unit testbench
// Drives directed and random conversion and table write words into the
// level curve unit under changing idle patterns on both channels, with one
// long receiver hold-off, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module level_curve_interp_unit_tb;
    import lci_pkg::*;
    import lci_tb_pkg::*;

    localparam int RESET_CYCLES = 2;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 64;
    localparam int PHASE_WORDS  = 330;

    logic                    aclk;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic                    s_action       = 1'b0;
    logic signed [RAW_W-1:0] s_raw_level    = '0;
    logic [IDX_W-1:0]        s_entry_index  = '0;
    logic signed [VAL_W-1:0] s_entry_value  = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic signed [VAL_W-1:0] m_level_liters;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int quiet_cycles  = 0;

    level_curve_interp_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_raw_level    (s_raw_level),
        .s_entry_index  (s_entry_index),
        .s_entry_value  (s_entry_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_level_liters (m_level_liters)
    );

    level_curve_interp_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_raw_level    (s_raw_level),
        .s_entry_index  (s_entry_index),
        .s_entry_value  (s_entry_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_level_liters (m_level_liters),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // Free-running clock with a period of 20.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offer one word and hold it until it is taken, then maybe idle a while.
    task automatic send_word(input lci_action_e act, input int raw, input int idx,
                             input int val);
        s_valid       <= 1'b1;
        s_action      <= act;
        s_raw_level   <= RAW_W'(raw);
        s_entry_index <= IDX_W'(idx);
        s_entry_value <= VAL_W'(val);
        do @(posedge aclk); while (!s_ready);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // One random word: mostly conversions spread over the interesting
    // reading ranges, with the odd table write mixed in.
    task automatic send_random_word();
        int pick;
        int raw;
        int idx;
        int val;
        int knee;
        pick = $urandom_range(99);
        raw  = $urandom;
        idx  = $urandom;
        val  = $urandom;
        if (pick < 12) begin
            // Half the writes keep the curve moderate, half use the full range.
            if ($urandom_range(1) == 0) begin
                val = int'($urandom_range(65535)) - 32768;
            end
            send_word(ACT_WRITE, raw, idx, val);
        end else begin
            if (pick < 22) begin
                raw = -int'($urandom_range(32768, 1));
            end else if (pick < 32) begin
                raw = $urandom_range(32767, 25600);
            end else if (pick < 47) begin
                // On or just either side of a table point.
                knee = $urandom_range(15);
                raw  = (knee * FULL_SCALE) / (TABLE_POINTS - 1) + int'($urandom_range(2)) - 1;
            end else begin
                raw = $urandom_range(25599, 1);
            end
            send_word(ACT_CONVERT, raw, idx, val);
        end
    endtask

    // Stop offering and wait for every outstanding result word.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Receiver: random back-pressure, with a long hold-off when asked.
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Count cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: give up when nothing has moved for too long.
    initial begin
        do @(posedge aclk); while (quiet_cycles < STALL_LIMIT);
        $display("level_curve_interp_unit regression: fail");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reading extremes, full scale and the first segment edge.
        send_word(ACT_CONVERT, 0, 0, 0);
        send_word(ACT_CONVERT, -32768, 15, -1);
        send_word(ACT_CONVERT, -1, 0, 0);
        send_word(ACT_CONVERT, 1, 0, 0);
        send_word(ACT_CONVERT, 1706, 0, 0);
        send_word(ACT_CONVERT, 1707, 0, 0);
        send_word(ACT_CONVERT, 12800, 0, 0);
        send_word(ACT_CONVERT, 25599, 0, 0);
        send_word(ACT_CONVERT, 25600, 0, 0);
        send_word(ACT_CONVERT, 32767, 0, 0);

        // Directed: extreme end entries, read back through both clamps.
        send_word(ACT_WRITE, 0, 0, -524288);
        send_word(ACT_WRITE, -1, 15, 524287);
        send_word(ACT_CONVERT, -5, 0, 0);
        send_word(ACT_CONVERT, 32767, 0, 0);
        send_word(ACT_CONVERT, 853, 0, 0);

        // Directed: a steeply descending segment in the middle.
        send_word(ACT_WRITE, 0, 7, 524287);
        send_word(ACT_WRITE, 0, 8, -524288);
        send_word(ACT_CONVERT, 12800, 0, 0);
        send_word(ACT_CONVERT, 12801, 0, 0);
        send_word(ACT_CONVERT, 11947, 0, 0);
        drain_results();

        // Random phases with different idle patterns on each side.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 34;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Long receiver hold-off while words keep arriving.
                if (phase == 2 && n == PHASE_WORDS / 2) begin
                    hold_requests++;
                end
                send_random_word();
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("level_curve_interp_unit regression: pass");
        end else begin
            $display("level_curve_interp_unit regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/lci_pkg.sv
sv/lci_seg_div.sv
sv/lci_table.sv
sv/lci_blend.sv
sv/level_curve_interp_unit.sv
sv/lci_port_checker.sv
tb/lci_tb_pkg.sv
tb/level_curve_interp_checker.sv
tb/level_curve_interp_unit_tb.sv
